/* rtl/ldds_pkg.sv */
// Shared types and constants for the LED daylight dimming schedule.
package ldds_pkg;

  // Width of the signed intermediate values of the schedule.
  localparam int SW = 20;

  localparam logic [1:0] REG_SUNRISE_HOUR   = 2'd0;
  localparam logic [1:0] REG_SUNRISE_MINUTE = 2'd1;
  localparam logic [1:0] REG_ON_HOURS       = 2'd2;

  localparam logic [4:0] RST_SUNRISE_HOUR   = 5'd9;
  localparam logic [5:0] RST_SUNRISE_MINUTE = 6'd0;
  localparam logic [4:0] RST_ON_HOURS       = 5'd9;

  localparam logic signed [SW-1:0] LVL_FULL    = SW'(4096);
  localparam logic signed [SW-1:0] RAMP_END    = SW'(6144);
  localparam logic signed [SW-1:0] SUNSET_LEAD = SW'(2048);
  localparam logic signed [SW-1:0] GLOW_LEVEL  = SW'(2048);
  localparam logic signed [SW-1:0] SEC_HOUR    = SW'(3600);
  localparam logic [12:0]          GLOW_MIN    = 13'd120;
  // 65536 / 3 rounded up; exact floor for dividends below 32768.
  localparam logic [14:0]          RECIP3      = 15'd21846;

  typedef struct packed {
    logic signed [SW-1:0] raw_w;
    logic signed [SW-1:0] raw_b;
    logic signed [SW-1:0] raw_u;
    logic                 keep_low;
  } sched_t;

  typedef struct packed {
    logic eq_now;
    logic eq_step;
  } lane_flags_t;

  typedef struct packed {
    logic stepped;
    logic fade_nxt;
  } merge_t;

endpackage

/* rtl/ldds_sched.sv */
// Daylight schedule: raw per-channel targets from time of day and settings.
module ldds_sched (
  input  logic [4:0]       sunrise_hour,
  input  logic [5:0]       sunrise_minute,
  input  logic [4:0]       on_hours,
  input  logic [4:0]       hour_now,
  input  logic [5:0]       minute_now,
  input  logic [5:0]       second_now,
  output ldds_pkg::sched_t sched
);
  import ldds_pkg::*;

  logic [10:0]          now_min;
  logic [10:0]          start_min;
  logic [11:0]          end_min;
  logic                 lit;
  logic                 glow;
  logic [10:0]          lit_diff;
  logic [16:0]          t_sec;
  logic [6:0]           glow_diff;
  logic [12:0]          sd_sec;
  logic [27:0]          q_prod;
  logic signed [SW-1:0] q_s;
  logic signed [SW-1:0] ts;
  logic signed [SW-1:0] bound;
  logic signed [SW-1:0] d_s;
  logic signed [SW-1:0] ramp;

  assign now_min   = 11'(hour_now) * 11'd60 + 11'(minute_now);
  assign start_min = 11'(sunrise_hour) * 11'd60 + 11'(sunrise_minute);
  assign end_min   = 12'(start_min) + 12'(on_hours) * 12'd60;

  assign lit  = (12'(now_min) >= 12'(start_min)) && (12'(now_min) < end_min);
  assign glow = (12'(now_min) >= end_min) && (13'(now_min) <= 13'(end_min) + GLOW_MIN);

  assign lit_diff = now_min - start_min;
  assign t_sec    = 17'(lit_diff) * 17'd60 + 17'(second_now);
  assign ts       = $signed(SW'(t_sec));
  assign bound    = $signed(SW'(on_hours)) * SEC_HOUR - SUNSET_LEAD;
  assign d_s      = ts - bound;
  assign ramp     = (ts - LVL_FULL) <<< 1;

  // Seconds into the afterglow stay below 7264, so the reciprocal is exact.
  assign glow_diff = 7'(12'(now_min) - end_min);
  assign sd_sec    = 13'(glow_diff) * 13'd60 + 13'(second_now);
  assign q_prod    = 28'(sd_sec) * 28'(RECIP3);
  assign q_s       = $signed(SW'(q_prod[27:16]));

  always_comb begin
    sched = '0;
    if (lit) begin
      if (ts < LVL_FULL) begin
        sched.raw_b = ts;
      end else if (ts < RAMP_END) begin
        sched.raw_w = ramp;
        sched.raw_b = LVL_FULL;
        sched.raw_u = ramp;
      end else if (ts >= bound) begin
        sched.raw_w    = LVL_FULL - (d_s <<< 1);
        sched.raw_b    = LVL_FULL - d_s;
        sched.raw_u    = LVL_FULL - (d_s <<< 1);
        sched.keep_low = 1'b1;
      end else begin
        sched.raw_w = LVL_FULL;
        sched.raw_b = LVL_FULL;
        sched.raw_u = LVL_FULL;
      end
    end else if (glow) begin
      sched.raw_b = GLOW_LEVEL - q_s;
    end
  end

endmodule

/* rtl/ldds_lane.sv */
// One channel lane: target selection, clamping and the one-count fade step.
module ldds_lane #(
  parameter int DB = 12
) (
  input  logic                        manual,
  input  logic [11:0]                 knob,
  input  logic signed [ldds_pkg::SW-1:0] raw,
  input  logic                        keep_low,
  input  logic [DB-1:0]               level,
  output logic [DB-1:0]               tgt,
  output logic [DB-1:0]               step,
  output ldds_pkg::lane_flags_t       flags
);
  import ldds_pkg::*;

  logic signed [SW-1:0] sel;
  logic signed [SW-1:0] max_s;
  logic [DB-1:0]        clamped;

  assign max_s = $signed(SW'({DB{1'b1}}));
  assign sel   = manual ? $signed(SW'(knob)) : raw;

  always_comb begin
    if (sel < 0) begin
      clamped = '0;
    end else if (sel > max_s) begin
      clamped = {DB{1'b1}};
    end else begin
      clamped = sel[DB-1:0];
    end
  end

  // During sunset a channel that is already nearly off stays where it is.
  assign tgt = (!manual && keep_low && (level < DB'(2))) ? level : clamped;

  always_comb begin
    if (level > tgt) begin
      step = level - DB'(1);
    end else if (level < tgt) begin
      step = level + DB'(1);
    end else begin
      step = level;
    end
  end

  assign flags.eq_now  = (level == tgt);
  assign flags.eq_step = (step == tgt);

endmodule

/* rtl/ldds_merge.sv */
// Merges the lane match flags into the fade decision for this beat.
module ldds_merge (
  input  logic                  fade_eff,
  input  ldds_pkg::lane_flags_t flags [3],
  output ldds_pkg::merge_t      mg
);
  import ldds_pkg::*;

  logic all_now;
  logic all_step;

  assign all_now  = flags[0].eq_now && flags[1].eq_now && flags[2].eq_now;
  assign all_step = flags[0].eq_step && flags[1].eq_step && flags[2].eq_step;

  assign mg.stepped  = fade_eff && !all_now;
  assign mg.fade_nxt = fade_eff && !all_now && !all_step;

endmodule

/* rtl/led_daylight_dimming_schedule.sv */
// Top level of the LED daylight dimming schedule with output buffering.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready    time of day, three knobs, mode
//   out_     output     out_valid / out_ready  three duty levels, fading
//   cfg_     input      cfg_we                 cfg_index, cfg_data
//
// One beat is accepted per cycle while in_ready is high, and its result is registered the next cycle.
// The duty levels close a loop through the three lanes and the merge.
// A two-entry output buffer keeps input accepted while one result is stalled.
// Synchronous reset sets levels to zero and starts with a fade-in.
module led_daylight_dimming_schedule #(
  parameter int DUTY_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           in_hour_now,
  input  logic [5:0]           in_minute_now,
  input  logic [5:0]           in_second_now,
  input  logic [11:0]          in_knob_white,
  input  logic [11:0]          in_knob_blue,
  input  logic [11:0]          in_knob_uv,
  input  logic                 in_manual_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_BITS-1:0] out_duty_white,
  output logic [DUTY_BITS-1:0] out_duty_blue,
  output logic [DUTY_BITS-1:0] out_duty_uv,
  output logic                 out_fading,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data
);
  import ldds_pkg::*;

  localparam int DB = DUTY_BITS;

  logic [4:0]    sunrise_hour_r;
  logic [5:0]    sunrise_minute_r;
  logic [4:0]    on_hours_r;

  logic [DB-1:0] lvl_r [3];
  logic [DB-1:0] lvl_nxt [3];
  logic          mode_was_manual_r;
  logic          fade_active_r;

  logic          out_valid_r;
  logic [DB-1:0] out_lvl_r [3];
  logic          out_fading_r;
  logic          skid_valid_r;
  logic [DB-1:0] skid_lvl_r [3];
  logic          skid_fading_r;

  sched_t                sched;
  logic signed [SW-1:0]  raw [3];
  logic                  keep [3];
  logic [11:0]           knob [3];
  logic [DB-1:0]         tgt [3];
  logic [DB-1:0]         step [3];
  lane_flags_t           flags [3];
  merge_t                mg;
  logic                  fade_eff;
  logic                  in_fire;
  logic                  pop;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sunrise_hour_r   <= RST_SUNRISE_HOUR;
      sunrise_minute_r <= RST_SUNRISE_MINUTE;
      on_hours_r       <= RST_ON_HOURS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SUNRISE_HOUR:   sunrise_hour_r   <= cfg_data[4:0];
        REG_SUNRISE_MINUTE: sunrise_minute_r <= cfg_data;
        REG_ON_HOURS:       on_hours_r       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  ldds_sched u_sched (
    .sunrise_hour   (sunrise_hour_r),
    .sunrise_minute (sunrise_minute_r),
    .on_hours       (on_hours_r),
    .hour_now       (in_hour_now),
    .minute_now     (in_minute_now),
    .second_now     (in_second_now),
    .sched          (sched)
  );

  assign raw[0]  = sched.raw_w;
  assign raw[1]  = sched.raw_b;
  assign raw[2]  = sched.raw_u;
  assign keep[0] = sched.keep_low;
  assign keep[1] = 1'b0;
  assign keep[2] = sched.keep_low;
  assign knob[0] = in_knob_white;
  assign knob[1] = in_knob_blue;
  assign knob[2] = in_knob_uv;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ldds_lane #(.DB(DB)) u_lane (
      .manual   (in_manual_mode),
      .knob     (knob[i]),
      .raw      (raw[i]),
      .keep_low (keep[i]),
      .level    (lvl_r[i]),
      .tgt      (tgt[i]),
      .step     (step[i]),
      .flags    (flags[i])
    );
    assign lvl_nxt[i] = mg.stepped ? step[i] : tgt[i];
  end

  // A mode change restarts the fade on the same beat.
  assign fade_eff = fade_active_r || (in_manual_mode != mode_was_manual_r);

  ldds_merge u_merge (
    .fade_eff (fade_eff),
    .flags    (flags),
    .mg       (mg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_was_manual_r <= 1'b0;
      fade_active_r     <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (in_fire) begin
      mode_was_manual_r <= in_manual_mode;
      fade_active_r     <= mg.fade_nxt;
      for (int i = 0; i < 3; i++) begin
        lvl_r[i] <= lvl_nxt[i];
      end
    end
  end

  // Output buffer: a new result goes to the output slot when it is free or
  // draining, otherwise to the skid slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid_r || pop) begin
        out_lvl_r    <= lvl_nxt;
        out_fading_r <= mg.stepped;
      end else begin
        skid_lvl_r    <= lvl_nxt;
        skid_fading_r <= mg.stepped;
      end
    end else if (pop && skid_valid_r) begin
      out_lvl_r    <= skid_lvl_r;
      out_fading_r <= skid_fading_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duty_white = out_lvl_r[0];
  assign out_duty_blue  = out_lvl_r[1];
  assign out_duty_uv    = out_lvl_r[2];
  assign out_fading     = out_fading_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a beat while the output slot is empty");

  a_fade_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mg.stepped) |=>
      ((lvl_r[1] == $past(lvl_r[1])) || (lvl_r[1] == $past(lvl_r[1]) + DB'(1)) ||
       (lvl_r[1] == $past(lvl_r[1]) - DB'(1))))
    else $error("fade step moved the blue level by more than one count");

  a_fade_clear_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(fade_active_r) |-> $past(in_fire))
    else $error("fade ended without an accepted beat");

  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> ($stable(lvl_r[0]) && $stable(lvl_r[1]) && $stable(lvl_r[2])))
    else $error("duty levels changed without an accepted beat");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && in_fire) |=> (skid_valid_r && !in_ready))
    else $error("stalled result was not parked in the skid slot");
`endif

endmodule
